// ----- rtl/sbw_pkg.sv -----
// shared constants, types and the arctangent table for the scan beam to world point block
package sbw_pkg;

  localparam int unsigned RotationStagesDef = 16;
  localparam int unsigned AtanEntries       = 24;

  localparam int unsigned AngleW  = 16;
  localparam int unsigned RangeW  = 16;
  localparam int unsigned PoseW   = 24;
  localparam int unsigned EndW    = 25;
  localparam int unsigned CfgIdxW = 2;

  // 2^-30 fixed point vector, 2^32 units per turn for the residual angle
  localparam int unsigned FracBits = 30;
  localparam int unsigned VecW     = 48;
  localparam int unsigned ZW       = 34;
  localparam int unsigned GainW    = 30;
  localparam int unsigned ProdW    = RangeW + GainW;
  localparam int unsigned RndW     = VecW - FracBits;

  localparam logic [GainW-1:0] GainComp = 30'd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPoseX    = 2'd0,
    CfgPoseY    = 2'd1,
    CfgHeading  = 2'd2,
    CfgReserved = 2'd3
  } cfg_idx_e;

  // arctan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 34'sd536870912;
      1:       a = 34'sd316933406;
      2:       a = 34'sd167458907;
      3:       a = 34'sd85004756;
      4:       a = 34'sd42667331;
      5:       a = 34'sd21354465;
      6:       a = 34'sd10679838;
      7:       a = 34'sd5340245;
      8:       a = 34'sd2670163;
      9:       a = 34'sd1335087;
      10:      a = 34'sd667544;
      11:      a = 34'sd333772;
      12:      a = 34'sd166886;
      13:      a = 34'sd83443;
      14:      a = 34'sd41722;
      15:      a = 34'sd20861;
      16:      a = 34'sd10430;
      17:      a = 34'sd5215;
      18:      a = 34'sd2608;
      19:      a = 34'sd1304;
      20:      a = 34'sd652;
      21:      a = 34'sd326;
      22:      a = 34'sd163;
      23:      a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/scan_beam_to_world_point.sv -----
// top level: pipelined cordic that turns range-finder beams into world end points
//
// Takes one beam (bearing, range, last flag) per clock and returns its world end point
// pose + range * (cos, sin)(beam_angle - pose_heading), rounded to the nearest millimetre.
// The pipeline registers are angle reduction, gain multiply, one register per cordic
// rotation, rounding and the pose add. Throughput is one beat per cycle; the whole
// pipeline holds while the output beat is stalled, and in_stall_o follows out_stall_i only
// when the output register is full. Pose registers are written through the cfg port and are
// meant to change only while no beam is in flight.
module scan_beam_to_world_point
  import sbw_pkg::*;
#(
  parameter int unsigned ROTATION_STAGES = RotationStagesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [PoseW-1:0]         cfg_wdata_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [AngleW-1:0] beam_angle_i,
  input  logic [RangeW-1:0]        beam_range_i,
  input  logic                     last_beam_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [EndW-1:0]   end_x_o,
  output logic signed [EndW-1:0]   end_y_o,
  output logic                     last_point_o
);

  localparam int unsigned NumStages =
    (ROTATION_STAGES < AtanEntries) ? ROTATION_STAGES : AtanEntries;

  // configuration
  logic signed [PoseW-1:0]  pose_x_q, pose_y_q;
  logic signed [AngleW-1:0] heading_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgPoseX:   pose_x_q  <= cfg_wdata_i;
        CfgPoseY:   pose_y_q  <= cfg_wdata_i;
        CfgHeading: heading_q <= cfg_wdata_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output beat is held
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage a: angle wrap and quadrant reduction
  logic                     a_valid_q;
  logic [RangeW-1:0]        a_range_q;
  logic                     a_neg_q;
  logic signed [AngleW-1:0] a_ang_q;
  logic                     a_last_q;
  logic signed [AngleW-1:0] diff;
  logic                     outside;

  assign diff    = beam_angle_i - heading_q;
  // outside [-quarter, quarter) when the two top bits differ
  assign outside = diff[AngleW-1] ^ diff[AngleW-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_range_q <= beam_range_i;
      a_neg_q   <= outside;
      // a half-turn move is a flip of the sign bit in 16-bit wrap arithmetic
      a_ang_q   <= {diff[AngleW-1] ^ outside, diff[AngleW-2:0]};
      a_last_q  <= last_beam_i;
    end
  end

  // stage b: gain compensation multiply, then the rotation stages
  logic                    vld_q  [NumStages+1];
  logic signed [VecW-1:0]  x_q    [NumStages+1];
  logic signed [VecW-1:0]  y_q    [NumStages+1];
  logic signed [ZW-1:0]    z_q    [NumStages+1];
  logic                    last_q [NumStages+1];
  logic [ProdW-1:0]        prod;
  logic signed [VecW-1:0]  prod_s;

  assign prod   = a_range_q * GainComp;
  assign prod_s = $signed(VecW'(prod));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]    <= a_neg_q ? -prod_s : prod_s;
      y_q[0]    <= '0;
      z_q[0]    <= {{(ZW-AngleW-16){a_ang_q[AngleW-1]}}, a_ang_q, 16'h0000};
      last_q[0] <= a_last_q;
    end
  end

  for (genvar g = 0; g < NumStages; g++) begin : g_rot
    localparam logic signed [ZW-1:0] Atan = atan_entry(g);
    logic signed [VecW-1:0] dx, dy;
    logic                   pos;

    assign dx  = y_q[g] >>> g;
    assign dy  = x_q[g] >>> g;
    assign pos = !z_q[g][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[g+1]    <= pos ? x_q[g] - dx   : x_q[g] + dx;
        y_q[g+1]    <= pos ? y_q[g] + dy   : y_q[g] - dy;
        z_q[g+1]    <= pos ? z_q[g] - Atan : z_q[g] + Atan;
        last_q[g+1] <= last_q[g];
      end
    end
  end

  // round to nearest millimetre, halves toward plus infinity
  localparam logic signed [VecW-1:0] Half = VecW'(1) <<< (FracBits - 1);

  logic                   r_valid_q;
  logic signed [RndW-1:0] r_x_q, r_y_q;
  logic                   r_last_q;
  logic signed [VecW-1:0] x_rnd, y_rnd;

  assign x_rnd = x_q[NumStages] + Half;
  assign y_rnd = y_q[NumStages] + Half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= vld_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_x_q    <= x_rnd[VecW-1:FracBits];
      r_y_q    <= y_rnd[VecW-1:FracBits];
      r_last_q <= last_q[NumStages];
    end
  end

  // output register: add the pose
  logic signed [EndW-1:0] end_x_d, end_y_d;
  logic signed [EndW-1:0] end_x_q, end_y_q;
  logic                   last_point_q;

  assign end_x_d = EndW'(pose_x_q) + EndW'(r_x_q);
  assign end_y_d = EndW'(pose_y_q) + EndW'(r_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      last_point_q <= r_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign end_x_o      = end_x_q;
  assign end_y_o      = end_y_q;
  assign last_point_o = last_point_q;

endmodule

// ----- sim/scan_beam_to_world_point_tb.sv -----
`timescale 1ns / 100ps
// scoreboard testbench for scan_beam_to_world_point: cordic predictor, random beats and poses
module scan_beam_to_world_point_tb;
  import sbw_pkg::*;

  localparam int unsigned Latency      = RotationStagesDef + 4;
  localparam int unsigned SettlePause  = 2 * Latency;
  localparam int unsigned WatchLimit   = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandPerPhase = 155;
  localparam int unsigned NumPhases    = 7;

  // arctan(2^-i) in 2^-32 turn units
  localparam longint ArcTab [AtanEntries] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  localparam logic [AngleW-1:0] DirAngles [10] = '{
    16'h0000, 16'h3FFF, 16'h4000, 16'hC000, 16'hBFFF,
    16'h7FFF, 16'h8000, 16'h2000, 16'hE000, 16'h6000
  };

  typedef struct packed {
    logic signed [EndW-1:0] x;
    logic signed [EndW-1:0] y;
    logic                   last;
  } world_point_t;

  typedef enum int {IdleNone, IdleSender, IdleRecv, IdleBoth} idle_mode_e;

  class end_point_board;
    logic signed [PoseW-1:0] pose_x;
    logic signed [PoseW-1:0] pose_y;
    logic [AngleW-1:0]       heading;
    world_point_t            pending_points[$];
    int unsigned             errors;
    int unsigned             matched;

    function new();
      pose_x  = '0;
      pose_y  = '0;
      heading = '0;
      errors  = 0;
      matched = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [PoseW-1:0] data);
      case (idx)
        CfgPoseX:   pose_x = data;
        CfgPoseY:   pose_y = data;
        CfgHeading: heading = data[AngleW-1:0];
        default: ;
      endcase
    endfunction

    function world_point_t rotate_beam(logic [AngleW-1:0] angle, logic [RangeW-1:0] range_mm,
                                       logic last);
      world_point_t      p;
      logic [AngleW-1:0] diff;
      longint            a, x, y, z, dx, dy, rx, ry;
      diff = angle - heading;
      a    = longint'($signed(diff));
      x    = longint'(range_mm) * longint'(GainComp);
      y    = 0;
      // fold into the right half plane, start vector flipped
      if (a >= 16384 || a < -16384) begin
        x = -x;
        a = (a > 0) ? a - 32768 : a + 32768;
      end
      z = a * 65536;
      for (int i = 0; i < RotationStagesDef && i < AtanEntries; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ArcTab[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ArcTab[i];
        end
      end
      rx     = (x + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
      ry     = (y + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
      p.x    = EndW'(longint'(pose_x) + rx);
      p.y    = EndW'(longint'(pose_y) + ry);
      p.last = last;
      return p;
    endfunction

    function void take_beam(logic [AngleW-1:0] angle, logic [RangeW-1:0] range_mm, logic last);
      world_point_t p;
      p = rotate_beam(angle, range_mm, last);
      pending_points = {pending_points, p};
    endfunction

    function void check_point(world_point_t got);
      world_point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time, got.x, got.y, got.last);
        return;
      end
      want = pending_points.pop_front();
      if (got.x !== want.x) begin
        errors++;
        $display("%0t: end_x expected %0d actual %0d", $time, want.x, got.x);
      end
      if (got.y !== want.y) begin
        errors++;
        $display("%0t: end_y expected %0d actual %0d", $time, want.y, got.y);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last_point expected %0b actual %0b", $time, want.last, got.last);
      end
      matched++;
    endfunction
  endclass

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i    = '0;
  logic [PoseW-1:0]         cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic signed [AngleW-1:0] beam_angle_i = '0;
  logic [RangeW-1:0]        beam_range_i = '0;
  logic                     last_beam_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [EndW-1:0]   end_x_o;
  logic signed [EndW-1:0]   end_y_o;
  logic                     last_point_o;

  end_point_board board;
  idle_mode_e     idle_mode     = IdleNone;
  bit             pressure_on   = 1'b0;
  bit             pressure_done = 1'b0;
  int unsigned    hold_left     = 0;
  int unsigned    quiet_cycles  = 0;
  int unsigned    beams_sent    = 0;
  world_point_t   seen_point;

  scan_beam_to_world_point u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .beam_angle_i (beam_angle_i),
    .beam_range_i (beam_range_i),
    .last_beam_i  (last_beam_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .end_x_o      (end_x_o),
    .end_y_o      (end_y_o),
    .last_point_o (last_point_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk_i) begin
    if (pressure_on && !pressure_done) begin
      hold_left     = HoldCycles;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (idle_mode == IdleRecv) begin
      out_stall_i <= ($urandom_range(0, 99) < 55);
    end else if (idle_mode == IdleBoth) begin
      out_stall_i <= ($urandom_range(0, 99) < 24);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_point.x    = end_x_o;
      seen_point.y    = end_y_o;
      seen_point.last = last_point_o;
      board.check_point(seen_point);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: no beat for %0d cycles, giving up", $time, WatchLimit);
      $display("scan_beam_to_world_point_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beam(input logic [AngleW-1:0] angle, input logic [RangeW-1:0] range_mm,
                           input logic last);
    int unsigned idle_pct;
    idle_pct = (idle_mode == IdleSender) ? 55 : (idle_mode == IdleBoth) ? 24 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    beam_angle_i <= angle;
    beam_range_i <= range_mm;
    last_beam_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_beam(angle, range_mm, last);
    beams_sent++;
  endtask

  task automatic rand_beam();
    logic [AngleW-1:0] angle;
    logic [RangeW-1:0] range_mm;
    int unsigned       pick;
    pick  = $urandom_range(0, 9);
    angle = AngleW'($urandom);
    case (pick)
      0:       range_mm = '0;
      1:       range_mm = '1;
      2:       range_mm = RangeW'($urandom_range(0, 255));
      default: range_mm = RangeW'($urandom);
    endcase
    // aim near the quadrant fold and the half turn, relative to the heading
    if (pick == 3 || pick == 4) begin
      case ($urandom_range(0, 5))
        0:       angle = board.heading + 16'h3FFF;
        1:       angle = board.heading + 16'h4000;
        2:       angle = board.heading + 16'hC000;
        3:       angle = board.heading + 16'hBFFF;
        4:       angle = board.heading + 16'h8000;
        default: angle = board.heading;
      endcase
    end
    send_beam(angle, range_mm, $urandom_range(0, 7) == 0);
  endtask

  task automatic drain_points();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (SettlePause) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [PoseW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task automatic write_pose(input logic [PoseW-1:0] px, input logic [PoseW-1:0] py,
                            input logic [AngleW-1:0] hd, input bit with_reserved);
    logic [7:0] junk;
    junk = 8'($urandom);
    put_reg(CfgPoseX, px);
    put_reg(CfgPoseY, py);
    // upper data bits of the heading write are don't-care
    put_reg(CfgHeading, {junk, hd});
    if (with_reserved) put_reg(CfgReserved, PoseW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : main_flow
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beams with the reset pose
    for (int k = 0; k < 10; k++) send_beam(DirAngles[k], 16'hFFFF, k == 9);
    for (int k = 0; k < 10; k++) send_beam(DirAngles[k], (k % 2 == 0) ? 16'd0 : 16'd1, k == 4);
    send_beam(16'h1234, 16'd1000, 1'b1);
    send_beam(16'h8001, 16'h8000, 1'b0);

    for (int ph = 1; ph <= NumPhases; ph++) begin
      drain_points();
      case (ph)
        1: begin
          write_pose(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 1'b0);
          idle_mode = IdleNone;
        end
        2: begin
          write_pose(24'h800000, 24'h800000, 16'h8000, 1'b0);
          idle_mode = IdleSender;
        end
        3: begin
          write_pose(PoseW'($urandom), PoseW'($urandom), AngleW'($urandom), 1'b1);
          idle_mode = IdleRecv;
        end
        4: begin
          write_pose(PoseW'($urandom), PoseW'($urandom), AngleW'($urandom), 1'b0);
          idle_mode   = IdleNone;
          pressure_on = 1'b1;
        end
        5: begin
          write_pose(24'h7FFFFF, 24'h800000, 16'h4000, 1'b0);
          idle_mode = IdleBoth;
        end
        6: begin
          write_pose(PoseW'($urandom), PoseW'($urandom), AngleW'($urandom), 1'b0);
          idle_mode = IdleBoth;
        end
        default: begin
          write_pose(24'h800000, 24'h7FFFFF, 16'hC000, 1'b0);
          idle_mode = IdleRecv;
        end
      endcase
      repeat (RandPerPhase) rand_beam();
    end

    drain_points();
    if (board.pending_points.size() != 0) begin
      board.errors++;
      $display("%0t: %0d points never arrived", $time, board.pending_points.size());
    end
    $display("run covered %0d beams and %0d checked points over %0d pose settings",
             beams_sent, board.matched, NumPhases + 1);
    $display("with pose extremes, all idle patterns and a %0d-cycle output hold-off", HoldCycles);
    if (board.errors == 0) begin
      $display("scan_beam_to_world_point_tb: done, clean");
    end else begin
      $display("scan_beam_to_world_point_tb: done, errors");
    end
    $finish;
  end

endmodule
